@@ rtl/core/tlv_pkg.sv @@
// Shared types and constants of the TLV stream parser.
package tlv_pkg;

    localparam logic [31:0] TLV_MAGIC_RESET   = 32'h544C_5631;
    localparam logic [7:0]  TLV_VERSION_RESET = 8'h01;
    localparam int          TLV_RESULT_DEPTH  = 4;

    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_MAGIC   = 2'd2,
        ST_VERSION = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic [7:0]  payload_byte;
        logic        last_of_record;
        status_t     status;
        logic        last;
    } tlv_result_t;

    // Queue status seen by the parser.
    typedef struct packed {
        logic room_for_two;
        logic valid;
    } tlv_queue_status_t;

endpackage

@@ rtl/core/tlv_stream_if.sv @@
// Valid/ready channels for input bytes and parser results.
interface tlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  record_type;
    logic [15:0] record_length;
    logic [7:0]  payload_byte;
    logic        last_of_record;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output kind, output record_type, output record_length,
                    output payload_byte, output last_of_record, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input record_type, input record_length,
                    input payload_byte, input last_of_record, input status,
                    input last, output ready);
endinterface

@@ rtl/core/tlv_result_fifo.sv @@
// Result queue that takes up to two results per cycle and gives one.
module tlv_result_fifo #(
    parameter int DEPTH = tlv_pkg::TLV_RESULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_cnt,
    input  tlv_pkg::tlv_result_t         push_data0,
    input  tlv_pkg::tlv_result_t         push_data1,
    input  logic                         pop,
    output tlv_pkg::tlv_queue_status_t   queue_status,
    output tlv_pkg::tlv_result_t         pop_data
);
    import tlv_pkg::*;

    // DEPTH must be a power of two, at least two.
    localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlv_result_t        entry_reg [DEPTH];
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        head_next  = do_pop ? head_reg + IDX_W'(1) : head_reg;
        tail_next  = tail_reg + IDX_W'(push_cnt);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[tail_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[tail_reg + IDX_W'(1)] <= push_data1;
        end
    end

    assign queue_status.valid        = (count_reg != '0);
    assign queue_status.room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop_data                  = entry_reg[head_reg];

endmodule

@@ rtl/core/tlv_stream_parser.sv @@
// Byte-serial type-length-value parser with header check and final status.
//
// One byte is accepted per clock cycle while the result queue has room for
// two results; each byte updates the parse state in the same cycle and its
// results are registered in the result queue, which gives them out one per
// cycle while the consumer is ready. A payload byte, or the last length byte
// of an empty record, that also carries the end flag gives two results, and
// the queue depth RESULT_DEPTH sets how much of that, or of a stalled
// consumer, is absorbed before the input stops accepting.
module tlv_stream_parser #(
    parameter int RESULT_DEPTH = tlv_pkg::TLV_RESULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tlv_in_if.sink      data,
    tlv_out_if.source   result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);
    import tlv_pkg::*;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HOLD    = 6'b100000
    } phase_t;

    logic [31:0]  magic_reg;
    logic [7:0]   version_reg;

    phase_t       phase_reg, phase_next;
    logic [2:0]   hdr_idx_reg, hdr_idx_next;
    logic [7:0]   type_reg, type_next;
    logic [15:0]  length_reg, length_next;
    logic [15:0]  remaining_reg, remaining_next;
    status_t      err_reg, err_next;

    logic [7:0]   want;
    logic [15:0]  rem_dec;
    logic [15:0]  len_full;
    logic [1:0]   n_results;
    tlv_result_t  res0, res1;
    logic         accept;
    logic         eob;
    logic [7:0]   b;

    tlv_queue_status_t queue_status;
    tlv_result_t       head_result;

    function automatic tlv_result_t status_result(input status_t st);
        tlv_result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        return r;
    endfunction

    assign accept = data.valid && data.ready;
    assign eob    = data.end_of_buffer;
    assign b      = data.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= TLV_MAGIC_RESET;
            version_reg <= TLV_VERSION_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MAGIC:   magic_reg   <= wr_data;
                REG_VERSION: version_reg <= wr_data[7:0];
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    // Expected header byte: magic word most significant byte first, then version.
    always_comb
    begin
        if (hdr_idx_reg[2])
        begin
            want = version_reg;
        end
        else
        begin
            case (hdr_idx_reg[1:0])
                2'd0:    want = magic_reg[31:24];
                2'd1:    want = magic_reg[23:16];
                2'd2:    want = magic_reg[15:8];
                default: want = magic_reg[7:0];
            endcase
        end
    end

    assign rem_dec  = remaining_reg - 16'd1;
    assign len_full = {length_reg[15:8], b};

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        err_next       = err_reg;
        n_results      = 2'd0;
        res0           = '0;
        res1           = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if ((b != want) && (err_reg == ST_OK))
                begin
                    err_next = hdr_idx_reg[2] ? ST_VERSION : ST_MAGIC;
                end
                if (eob)
                begin
                    // A short header reports truncation over any mismatch.
                    res0      = status_result(hdr_idx_reg[2] ? err_next : ST_TRUNC);
                    n_results = 2'd1;
                end
                else if (hdr_idx_reg[2])
                begin
                    phase_next   = (err_next != ST_OK) ? PH_HOLD : PH_TYPE;
                    hdr_idx_next = '0;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
            end
            PH_TYPE:
            begin
                type_next = b;
                if (eob)
                begin
                    res0      = status_result(ST_TRUNC);
                    n_results = 2'd1;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                length_next = {b, 8'h00};
                if (eob)
                begin
                    res0      = status_result(ST_TRUNC);
                    n_results = 2'd1;
                end
                else
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                length_next    = len_full;
                remaining_next = len_full;
                if (len_full == 16'd0)
                begin
                    res0.kind           = KIND_EMPTY;
                    res0.record_type    = type_reg;
                    res0.last_of_record = 1'b1;
                    res1                = status_result(ST_OK);
                    n_results           = eob ? 2'd2 : 2'd1;
                    phase_next          = PH_TYPE;
                end
                else if (eob)
                begin
                    res0      = status_result(ST_TRUNC);
                    n_results = 2'd1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                remaining_next      = rem_dec;
                res0.kind           = KIND_PAYLOAD;
                res0.record_type    = type_reg;
                res0.record_length  = length_reg;
                res0.payload_byte   = b;
                res0.last_of_record = (rem_dec == 16'd0);
                res1                = status_result((rem_dec == 16'd0) ? ST_OK : ST_TRUNC);
                n_results           = eob ? 2'd2 : 2'd1;
                if (rem_dec == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_HOLD:
            begin
                if (eob)
                begin
                    res0      = status_result(err_reg);
                    n_results = 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        // The end flag starts a new buffer with the next byte.
        if (eob)
        begin
            phase_next     = PH_HEADER;
            hdr_idx_next   = '0;
            type_next      = '0;
            length_next    = '0;
            remaining_next = '0;
            err_next       = ST_OK;
        end

        if (n_results == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_results == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            type_reg      <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            err_reg       <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            err_reg       <= err_next;
        end
    end

    tlv_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (accept ? n_results : 2'd0),
        .push_data0   (res0),
        .push_data1   (res1),
        .pop          (result.ready),
        .queue_status (queue_status),
        .pop_data     (head_result)
    );

    assign data.ready            = queue_status.room_for_two;
    assign result.valid          = queue_status.valid;
    assign result.kind           = head_result.kind;
    assign result.record_type    = head_result.record_type;
    assign result.record_length  = head_result.record_length;
    assign result.payload_byte   = head_result.payload_byte;
    assign result.last_of_record = head_result.last_of_record;
    assign result.status         = head_result.status;
    assign result.last           = head_result.last;

    a_eob_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (data.valid && data.ready && data.end_of_buffer) |=>
            (phase_reg == PH_HEADER && hdr_idx_reg == 3'd0 && err_reg == ST_OK))
        else $error("parse state not cleared after end of buffer");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with no bytes remaining");

    a_hold_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HOLD) |-> (err_reg != ST_OK))
        else $error("hold phase without a latched error");

    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_idx_reg <= 3'd4) && ((phase_reg == PH_HEADER) || (hdr_idx_reg == 3'd0)))
        else $error("header index out of range");

endmodule

@@ verif/tlv_stream_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the TLV stream parser, with its own byte-level prediction.
module tlv_stream_parser_tb;
    import tlv_pkg::*;

    localparam int          DIRECTED_ROWS   = 32;
    localparam int unsigned ITEMS_PER_PHASE = 320;
    localparam int unsigned CONFIG_PHASES   = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned CHOKE_CYCLES    = 240;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_HOLD    = 3'd5
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       typed;
        status_t    typed_st;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;

    tlv_in_if  in_ch ();
    tlv_out_if out_ch ();

    tlv_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .data     (in_ch),
        .result   (out_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #6 clk = ~clk;

    // Parser state as the testbench sees it.
    parse_phase_t ph;
    logic [2:0]   hdr_pos;
    logic [7:0]   rec_type;
    logic [15:0]  rec_len;
    logic [15:0]  bytes_left;
    status_t      latched_err;
    logic [31:0]  cfg_magic   = TLV_MAGIC_RESET;
    logic [7:0]   cfg_version = TLV_VERSION_RESET;

    tlv_result_t  step_events [$];
    tlv_result_t  pending_events [$];
    logic [8:0]   frame_q [$];

    int unsigned  mismatch_count = 0;
    int unsigned  results_seen   = 0;
    int unsigned  bytes_sent     = 0;
    int unsigned  frames_sent    = 0;
    int unsigned  settings_used  = 0;
    int unsigned  choke_cycles   = 0;
    int unsigned  burst_frames   = 0;

    stim_row_t dir_rows [DIRECTED_ROWS] = '{
        // Flag on the first byte, which is also wrong: still truncated.
        '{8'h00, 1'b1, 1'b1, ST_TRUNC},
        // Good magic, wrong version, flag on the fifth byte.
        '{8'h54, 1'b0, 1'b0, ST_OK},
        '{8'h4C, 1'b0, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b0, ST_OK},
        '{8'h31, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_VERSION},
        // Both magic and version wrong: the magic fault wins.
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h4C, 1'b0, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b0, ST_OK},
        '{8'h31, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_MAGIC},
        // Empty record, then a one-byte record whose byte carries the flag.
        '{8'h54, 1'b0, 1'b0, ST_OK},
        '{8'h4C, 1'b0, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b0, ST_OK},
        '{8'h31, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b0, ST_OK},
        // Record of the largest length, cut off after its first byte.
        '{8'h54, 1'b0, 1'b0, ST_OK},
        '{8'h4C, 1'b0, 1'b0, ST_OK},
        '{8'h56, 1'b0, 1'b0, ST_OK},
        '{8'h31, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'h7F, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b0, ST_OK}
    };

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic reset_parser();
        ph          = PH_HEADER;
        hdr_pos     = '0;
        rec_type    = '0;
        rec_len     = '0;
        bytes_left  = '0;
        latched_err = ST_OK;
    endtask

    function automatic tlv_result_t status_event(input status_t st);
        tlv_result_t ev;
        ev                = '0;
        ev.kind           = KIND_STATUS;
        ev.status         = st;
        ev.last           = 1'b1;
        return ev;
    endfunction

    function automatic tlv_result_t data_event(input kind_t k, input logic [15:0] len,
                                               input logic [7:0] pb, input logic lor);
        tlv_result_t ev;
        ev                = '0;
        ev.kind           = k;
        ev.record_type    = rec_type;
        ev.record_length  = len;
        ev.payload_byte   = pb;
        ev.last_of_record = lor;
        ev.status         = ST_OK;
        return ev;
    endfunction

    // Advances the parser by one byte and leaves its results in step_events.
    task automatic advance_parser(input logic [7:0] b, input logic eob);
        logic [7:0]  want;
        tlv_result_t ev;
        step_events.delete();
        case (ph)
            PH_HEADER:
            begin
                want = (hdr_pos < 3'd4) ? cfg_magic[8 * (3 - hdr_pos) +: 8] : cfg_version;
                if (b != want && latched_err == ST_OK)
                    latched_err = (hdr_pos < 3'd4) ? ST_MAGIC : ST_VERSION;
                if (eob)
                    step_events.push_back(status_event((hdr_pos < 3'd4) ? ST_TRUNC : latched_err));
                else if (hdr_pos >= 3'd4)
                begin
                    ph      = (latched_err != ST_OK) ? PH_HOLD : PH_TYPE;
                    hdr_pos = '0;
                end
                else
                    hdr_pos = hdr_pos + 3'd1;
            end
            PH_TYPE:
            begin
                rec_type = b;
                if (eob)
                    step_events.push_back(status_event(ST_TRUNC));
                else
                    ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                rec_len = {b, 8'h00};
                if (eob)
                    step_events.push_back(status_event(ST_TRUNC));
                else
                    ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                rec_len    = {rec_len[15:8], b};
                bytes_left = rec_len;
                if (rec_len == 16'd0)
                begin
                    step_events.push_back(data_event(KIND_EMPTY, 16'd0, 8'd0, 1'b1));
                    if (eob)
                        step_events.push_back(status_event(ST_OK));
                    ph = PH_TYPE;
                end
                else if (eob)
                    step_events.push_back(status_event(ST_TRUNC));
                else
                    ph = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                bytes_left = bytes_left - 16'd1;
                step_events.push_back(data_event(KIND_PAYLOAD, rec_len, b, bytes_left == 16'd0));
                if (bytes_left == 16'd0)
                    ph = PH_TYPE;
                if (eob)
                    step_events.push_back(status_event((bytes_left == 16'd0) ? ST_OK : ST_TRUNC));
            end
            default:
            begin
                if (eob)
                    step_events.push_back(status_event(latched_err));
            end
        endcase
        if (eob)
            reset_parser();
        if (step_events.size() > 0)
        begin
            ev      = step_events.pop_back();
            ev.last = 1'b1;
            step_events.push_back(ev);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic eob, input int unsigned gap,
                             input logic typed, input status_t typed_st);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_buffer <= eob;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        advance_parser(b, eob);
        if (typed)
            pending_events.push_back(status_event(typed_st));
        else
            foreach (step_events[i])
                pending_events.push_back(step_events[i]);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_config(input logic [31:0] magic, input logic [7:0] version);
        wr_en    <= 1'b1;
        wr_index <= REG_MAGIC;
        wr_data  <= magic;
        @(negedge clk);
        wr_index <= REG_VERSION;
        wr_data  <= {24'h0, version};
        @(negedge clk);
        wr_en    <= 1'b0;
        cfg_magic   = magic;
        cfg_version = version;
        settings_used++;
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 300);
    endfunction

    task automatic queue_record(input int unsigned len, input int unsigned nbytes);
        frame_q.push_back({1'b0, 8'($urandom)});
        frame_q.push_back({1'b0, len[15:8]});
        frame_q.push_back({1'b0, len[7:0]});
        repeat (nbytes) frame_q.push_back({1'b0, 8'($urandom)});
    endtask

    // Mostly well-formed buffers; some with header faults, cut-off records or pure noise.
    task automatic build_frame();
        int unsigned shape;
        int unsigned len;
        int unsigned cut;
        logic [8:0]  tail;
        frame_q.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
            repeat ($urandom_range(1, 12)) frame_q.push_back({1'b0, 8'($urandom)});
        else
        begin
            for (int k = 0; k < 4; k++)
                frame_q.push_back({1'b0, cfg_magic[8 * (3 - k) +: 8]});
            frame_q.push_back({1'b0, cfg_version});
            if (shape < 18)
                frame_q[$urandom_range(0, 4)] = {1'b0, 8'($urandom)};
            repeat ($urandom_range(0, 4))
            begin
                len = pick_length();
                queue_record(len, len);
            end
            if (shape >= 18 && shape < 26)
                queue_record($urandom_range(0, 65535), $urandom_range(0, 5));
            else if (shape >= 26 && shape < 34)
            begin
                cut = $urandom_range(1, frame_q.size());
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        tail = frame_q.pop_back();
        frame_q.push_back({1'b1, tail[7:0]});
    endtask

    function automatic int unsigned sender_gap(input logic burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_frame();
        logic burst;
        burst = (burst_frames > 0) || ($urandom_range(0, 4) == 0);
        if (burst_frames > 0)
            burst_frames--;
        foreach (frame_q[k])
            send_byte(frame_q[k][7:0], frame_q[k][8], sender_gap(burst), 1'b0, ST_OK);
        frames_sent++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // Result side: random hold-offs per result, occasional runs with ready held high.
    initial
    begin
        int unsigned gap;
        logic        rx_burst;
        tlv_result_t want;
        rx_burst     = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = ~rx_burst;
            if (choke_cycles > 0)
                gap = choke_cycles;
            else
                gap = rx_burst ? 0 : $urandom_range(0, 16);
            choke_cycles = 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            results_seen++;
            if (pending_events.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            else
            begin
                want = pending_events.pop_front();
                check_field("kind",           out_ch.kind,           want.kind);
                check_field("record_type",    out_ch.record_type,    want.record_type);
                check_field("record_length",  out_ch.record_length,  want.record_length);
                check_field("payload_byte",   out_ch.payload_byte,   want.payload_byte);
                check_field("last_of_record", out_ch.last_of_record, want.last_of_record);
                check_field("status",         out_ch.status,         want.status);
                check_field("last",           out_ch.last,           want.last);
            end
            @(negedge clk);
        end
    end

    // Ends the run if neither side moves a request for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tlv_stream_parser: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned phase_start;
        logic [31:0] magic_set [CONFIG_PHASES];
        logic [7:0]  version_set [CONFIG_PHASES];
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.end_of_buffer = 1'b0;
        wr_en               = 1'b0;
        wr_index            = REG_MAGIC;
        wr_data             = 32'h0;
        reset_parser();
        magic_set[0]   = TLV_MAGIC_RESET;
        version_set[0] = TLV_VERSION_RESET;
        magic_set[1]   = 32'h0000_0000;
        version_set[1] = 8'h00;
        magic_set[2]   = 32'hFFFF_FFFF;
        version_set[2] = 8'hFF;
        magic_set[3]   = $urandom;
        version_set[3] = 8'($urandom);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run on the register values left by reset.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(dir_rows[i].data, dir_rows[i].eob, sender_gap(1'b0),
                      dir_rows[i].typed, dir_rows[i].typed_st);
        drain();

        for (int p = 0; p < CONFIG_PHASES; p++)
        begin
            apply_config(magic_set[p], version_set[p]);
            if (p == 1)
            begin
                // Long stall on the result side while bytes keep coming back to back.
                choke_cycles = CHOKE_CYCLES;
                burst_frames = 4;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
            begin
                build_frame();
                send_frame();
            end
            drain();
        end

        $display("Sent %0d bytes in %0d random buffers under %0d register settings.",
                 bytes_sent, frames_sent, settings_used);
        $display("Checked %0d results: payload, empty-record and final status events.",
                 results_seen);
        if (mismatch_count == 0)
            $display("tlv_stream_parser: match");
        else
            $display("tlv_stream_parser: mismatch");
        $finish;
    end

endmodule

@@ tlv_stream_parser.f @@
rtl/core/tlv_pkg.sv
rtl/core/tlv_stream_if.sv
rtl/core/tlv_result_fifo.sv
rtl/core/tlv_stream_parser.sv
verif/tlv_stream_parser_tb.sv
